FILE: src/efwa_pkg.sv
`default_nettype none

package efwa_pkg;

    // Field widths of the job and result beats.
    localparam int DUR_W  = 32;
    localparam int TIME_W = 48;
    localparam int WIDX_W = 4;

    // Worker-count configuration register.
    localparam int CFG_W = 5;
    localparam logic [CFG_W-1:0] ACTIVE_WORKERS_RESET = 5'd16;

    // One result beat.
    typedef struct packed {
        logic [WIDX_W-1:0] worker_index;
        logic [TIME_W-1:0] start_time;
    } t_result;

endpackage

`default_nettype wire

FILE: src/efwa_if.sv
`default_nettype none

// Job channel: one beat carries the duration of one job.
interface efwa_job_if
    import efwa_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [DUR_W-1:0] job_duration;

    modport source (output valid, output job_duration, input ready);
    modport sink   (input valid, input job_duration, output ready);
endinterface

// Result channel: one beat per job, the chosen worker and its start time.
interface efwa_res_if
    import efwa_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WIDX_W-1:0] worker_index;
    logic [TIME_W-1:0] start_time;

    modport source (output valid, output worker_index, output start_time, input ready);
    modport sink   (input valid, input worker_index, input start_time, output ready);
endinterface

`default_nettype wire

FILE: src/earliest_free_worker_assigner.sv
// Earliest-free worker assigner. Each job beat is given to the active worker
// whose next-free time is smallest (lowest index on a tie); the result beat
// reports that worker and its free time as the job's start time, and the
// worker's free time then grows by the job duration, saturating at 2^48-1.
// The free times live in a small RAM that one comparator scans one entry per
// cycle, over the effective worker count (the register value, with zero
// taken as one and values above MAX_WORKERS taken as MAX_WORKERS). The
// result sits in an output register, and the next job can be accepted in
// the cycle after the write-back, so a new job is not taken before the last
// one is through; a previous result still waiting in the output register
// holds the write-back until it is taken. After reset a clearing pass over
// all MAX_WORKERS entries zeroes the RAM, and no job is accepted during it.
// Write active_workers only while idle.
`default_nettype none

module earliest_free_worker_assigner
    import efwa_pkg::*;
#(
    parameter int MAX_WORKERS = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_wdata,
    efwa_job_if.sink              i_job,
    efwa_res_if.source            o_res
);

    localparam int CNT_W = $clog2(MAX_WORKERS + 1);

    logic [CFG_W-1:0] r_active_workers;
    logic [CNT_W-1:0] w_worker_count;
    t_result          w_res;

    // Worker-count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_workers <= ACTIVE_WORKERS_RESET;
        end else if (i_cfg_we) begin
            r_active_workers <= i_cfg_wdata;
        end
    end

    // Clamp the register to the range of workers that exist.
    always_comb begin
        if (r_active_workers == '0) begin
            w_worker_count = CNT_W'(1);
        end else if (32'(r_active_workers) > 32'(MAX_WORKERS)) begin
            w_worker_count = CNT_W'(MAX_WORKERS);
        end else begin
            w_worker_count = CNT_W'(r_active_workers);
        end
    end

    efwa_sched #(
        .MAX_WORKERS (MAX_WORKERS)
    ) u_sched (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_worker_count (w_worker_count),
        .i_job_valid    (i_job.valid),
        .o_job_ready    (i_job.ready),
        .i_job_duration (i_job.job_duration),
        .o_res_valid    (o_res.valid),
        .i_res_ready    (o_res.ready),
        .o_res          (w_res)
    );

    assign o_res.worker_index = w_res.worker_index;
    assign o_res.start_time   = w_res.start_time;

endmodule

`default_nettype wire

FILE: src/efwa_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module efwa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: src/efwa_sched.sv
`default_nettype none

// Sequencer around one comparator and one saturating adder. It clears the
// free-time RAM after reset, then per job scans the active workers one per
// cycle, keeps the running minimum and writes back the updated free time.
module efwa_sched
    import efwa_pkg::*;
#(
    parameter int MAX_WORKERS = 16,
    parameter int IDX_W       = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1,
    parameter int CNT_W       = $clog2(MAX_WORKERS + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [CNT_W-1:0] i_worker_count,
    input  wire logic             i_job_valid,
    output logic                  o_job_ready,
    input  wire logic [DUR_W-1:0] i_job_duration,
    output logic                  o_res_valid,
    input  wire logic             i_res_ready,
    output t_result               o_res
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_UPDATE = 3'd4;

    localparam logic [IDX_W-1:0] LAST_ENTRY = IDX_W'(MAX_WORKERS - 1);

    logic [2:0]        r_state, n_state;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [IDX_W-1:0]  r_last, n_last;
    logic [DUR_W-1:0]  r_dur, n_dur;
    logic              r_dv, n_dv;
    logic [IDX_W-1:0]  r_didx, n_didx;
    logic [IDX_W-1:0]  r_best_idx, n_best_idx;
    logic [TIME_W-1:0] r_best_time, n_best_time;
    logic              r_out_valid, n_out_valid;
    t_result           r_out, n_out;

    logic              w_we;
    logic [IDX_W-1:0]  w_waddr;
    logic [TIME_W-1:0] w_wdata;
    logic [TIME_W-1:0] w_rdata;
    logic [TIME_W:0]   w_sum;
    logic [TIME_W-1:0] w_next_time;
    logic              w_take;
    logic              w_slot_free;

    // Free-time store, one entry per worker.
    efwa_ram #(
        .WIDTH (TIME_W),
        .DEPTH (MAX_WORKERS),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    // Shared comparator: the first worker always loads, later ones only if
    // strictly earlier, so ties keep the lowest index.
    assign w_take = r_dv && ((r_didx == '0) || (w_rdata < r_best_time));

    // Shared adder with saturation at the top of the time range.
    assign w_sum       = {1'b0, r_best_time} + (TIME_W + 1)'(r_dur);
    assign w_next_time = w_sum[TIME_W] ? {TIME_W{1'b1}} : w_sum[TIME_W-1:0];

    assign w_slot_free = !r_out_valid || i_res_ready;

    // RAM write port: zero during the clearing pass, else the winner's update.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = '0;
        if (r_state == ST_CLEAR) begin
            w_we = 1'b1;
        end else if (r_state == ST_UPDATE && w_slot_free) begin
            w_we    = 1'b1;
            w_waddr = r_best_idx;
            w_wdata = w_next_time;
        end
    end

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_last      = r_last;
        n_dur       = r_dur;
        n_dv        = r_dv;
        n_didx      = r_didx;
        n_best_idx  = r_best_idx;
        n_best_time = r_best_time;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_out_valid && i_res_ready) begin
            n_out_valid = 1'b0;
        end

        if (w_take) begin
            n_best_idx  = r_didx;
            n_best_time = w_rdata;
        end

        case (r_state)
            ST_CLEAR: begin
                n_idx = r_idx + 1'b1;
                if (r_idx == LAST_ENTRY) begin
                    n_idx   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_job_valid) begin
                    n_dur   = i_job_duration;
                    n_last  = IDX_W'(i_worker_count - 1'b1);
                    n_idx   = '0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                n_dv   = 1'b1;
                n_didx = r_idx;
                if (r_idx == r_last) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_DRAIN: begin
                n_dv    = 1'b0;
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (w_slot_free) begin
                    n_out_valid        = 1'b1;
                    n_out.worker_index = WIDX_W'(r_best_idx);
                    n_out.start_time   = r_best_time;
                    n_idx              = '0;
                    n_state            = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_idx       <= '0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_dv        <= n_dv;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_last      <= n_last;
        r_dur       <= n_dur;
        r_didx      <= n_didx;
        r_best_idx  <= n_best_idx;
        r_best_time <= n_best_time;
        r_out       <= n_out;
    end

    assign o_job_ready = (r_state == ST_IDLE);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

`default_nettype wire

FILE: src/efwa_checker.sv
`default_nettype none

// Port-level checks of the assigner.
module efwa_assertions
    import efwa_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_job_valid,
    input wire logic              i_job_ready,
    input wire logic              i_res_valid,
    input wire logic              i_res_ready,
    input wire logic [WIDX_W-1:0] i_worker_index,
    input wire logic [TIME_W-1:0] i_start_time
);

    logic       w_job_beat;
    logic       w_res_beat;
    logic [2:0] r_pending, n_pending;

    assign w_job_beat = i_job_valid && i_job_ready;
    assign w_res_beat = i_res_valid && i_res_ready;

    // Jobs accepted whose result beat has not yet been taken.
    always_comb begin
        n_pending = r_pending;
        if (w_job_beat && !w_res_beat) begin
            n_pending = r_pending + 1'b1;
        end else if (!w_job_beat && w_res_beat) begin
            n_pending = r_pending - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    // One job at a time: the block closes its input right after a job beat.
    a_busy_after_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_job_beat |=> !i_job_ready)
        else $error("job accepted on consecutive cycles");

    // A stalled result beat keeps its contents.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=>
            (i_res_valid && $stable(i_worker_index) && $stable(i_start_time)))
        else $error("stalled result beat changed");

    // No result beat without a job that caused it.
    a_res_has_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (r_pending != '0))
        else $error("result beat without a pending job");

    // At most one result waiting and one job in work.
    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 3'd2)
        else $error("too many jobs outstanding");

endmodule

bind earliest_free_worker_assigner efwa_assertions u_efwa_assertions (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_job_valid    (i_job.valid),
    .i_job_ready    (i_job.ready),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_worker_index (o_res.worker_index),
    .i_start_time   (o_res.start_time)
);

`default_nettype wire

FILE: tb/efwa_checker.sv
`default_nettype none

// Watches the job, result and configuration ports of the assigner. It keeps
// its own copy of the worker free times and the worker count, works out the
// assignment for every accepted job beat, and compares each result beat with
// the oldest outstanding assignment.
module efwa_checker
    import efwa_pkg::*;
#(
    parameter int MAX_WORKERS = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_wdata,
    efwa_job_if                   i_job,
    efwa_res_if                   i_res,
    output int                    o_fail_count,
    output int                    o_outstanding
);

    logic [TIME_W-1:0] free_time [MAX_WORKERS];
    logic [CFG_W-1:0]  worker_count = ACTIVE_WORKERS_RESET;
    t_result           pending_assignments [$];
    int                mismatches = 0;
    int                in_flight  = 0;

    assign o_fail_count  = mismatches;
    assign o_outstanding = in_flight;

    // Picks the earliest-free active worker (lowest index on a tie), returns
    // the assignment and books the job onto that worker, saturating the sum.
    function automatic t_result dispatch_job(input logic [DUR_W-1:0] dur);
        int              n;
        int              best;
        logic [TIME_W:0] sum;
        t_result         r;
        n = (worker_count == '0) ? 1 : int'(worker_count);
        if (n > MAX_WORKERS) n = MAX_WORKERS;
        best = 0;
        for (int w = 1; w < n; w++) begin
            if (free_time[w] < free_time[best]) best = w;
        end
        r.worker_index = WIDX_W'(best);
        r.start_time   = free_time[best];
        sum = {1'b0, free_time[best]} + (TIME_W + 1)'(dur);
        free_time[best] = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
        return r;
    endfunction

    function automatic void report_mismatch(input string what, input logic [63:0] want,
                                            input logic [63:0] got);
        mismatches++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    endfunction

    // Result beats are checked before the job beat of the same edge is
    // booked, so a result never matches the job accepted alongside it.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        logic    pushed;
        logic    popped;
        pushed = 1'b0;
        popped = 1'b0;
        if (!i_rst_n) begin
            foreach (free_time[w]) free_time[w] = '0;
            worker_count = ACTIVE_WORKERS_RESET;
            pending_assignments.delete();
            in_flight <= 0;
        end else begin
            if (i_res.valid === 1'b1 && i_res.ready === 1'b1) begin
                got.worker_index = i_res.worker_index;
                got.start_time   = i_res.start_time;
                if (pending_assignments.size() == 0) begin
                    mismatches++;
                    $display({"%0t: result beat with no job outstanding, expected none, ",
                              "got worker %0d start %0h"},
                             $time, got.worker_index, got.start_time);
                end else begin
                    want   = pending_assignments.pop_front();
                    popped = 1'b1;
                    if (got.worker_index !== want.worker_index)
                        report_mismatch("worker_index", 64'(want.worker_index),
                                        64'(got.worker_index));
                    if (got.start_time !== want.start_time)
                        report_mismatch("start_time", 64'(want.start_time),
                                        64'(got.start_time));
                end
            end
            if (i_job.valid === 1'b1 && i_job.ready === 1'b1) begin
                pending_assignments.push_back(dispatch_job(i_job.job_duration));
                pushed = 1'b1;
            end
            if (i_cfg_we === 1'b1) worker_count = i_cfg_wdata;
            in_flight <= in_flight + int'(pushed) - int'(popped);
        end
    end

endmodule

`default_nettype wire

FILE: tb/tb.sv
`default_nettype none

// Drives job beats and worker-count writes into the assigner, stalls the
// result side at random, and gives the verdict from the checker's count.
module tb;
    import efwa_pkg::*;

    localparam int MAX_WORKERS   = 16;
    localparam int RANDOM_PHASES = 24;
    localparam int PHASE_JOBS    = 80;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    int               fail_count;
    int               outstanding;
    int               idle_level = 0;
    int               stall_left = 0;

    efwa_job_if job_ch ();
    efwa_res_if res_ch ();

    earliest_free_worker_assigner #(
        .MAX_WORKERS(MAX_WORKERS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_job      (job_ch),
        .o_res      (res_ch)
    );

    efwa_checker #(
        .MAX_WORKERS(MAX_WORKERS)
    ) checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_job        (job_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_outstanding(outstanding)
    );

    // Clock with a period of two time units.
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Result-side back-pressure: bursts of stalled cycles, more often at higher
    // idle levels, none at level zero.
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (stall_left > 0) begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end else if (idle_level > 0 && $urandom_range(0, 7) < idle_level) begin
                stall_left = $urandom_range(0, 4);
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Sends one job beat, possibly after a short gap, and returns at the edge
    // where it is accepted. Valid stays high so a following job can follow
    // back to back.
    task automatic send_job(input logic [DUR_W-1:0] dur);
        int gap;
        gap = 0;
        if (idle_level > 0 && $urandom_range(0, 7) < idle_level) gap = $urandom_range(1, 5);
        if (gap > 0) begin
            job_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        job_ch.valid        <= 1'b1;
        job_ch.job_duration <= dur;
        do @(posedge clk); while (job_ch.ready !== 1'b1);
    endtask

    // Lets every outstanding job finish and the write-back settle before the
    // worker count changes.
    task automatic set_workers(input logic [CFG_W-1:0] count);
        job_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= count;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mix of durations: full range, tiny values that force ties, midsize, and the extremes zero and all ones.
    function automatic logic [DUR_W-1:0] random_duration();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return DUR_W'($urandom_range(0, 3));
            2:       return DUR_W'($urandom_range(0, 1000));
            default: return ($urandom_range(0, 1) == 0) ? '0 : '1;
        endcase
    endfunction

    // Stimulus: reset, a directed opening, random phases and the final verdict.
    initial begin
        logic [CFG_W-1:0] count;
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        job_ch.valid        = 1'b0;
        job_ch.job_duration = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Ties on worker 0, extreme durations, then the spread over workers.
        send_job('0);
        send_job('0);
        send_job('1);
        send_job(32'd1);
        send_job(32'd1);
        send_job(32'h8000_0000);
        send_job(32'd7);

        // A count of zero acts as one worker.
        set_workers(5'd0);
        send_job(32'd3);
        send_job(32'd3);

        // Counts above the worker total act as the full set.
        set_workers(5'd31);
        send_job(32'd2);
        send_job(32'd2);
        set_workers(5'd17);
        send_job(32'd9);

        // Narrow to two, then let the idle workers rejoin with their old times.
        set_workers(5'd2);
        send_job('0);
        send_job(32'd5);
        set_workers(5'd16);
        send_job(32'd4);
        send_job(32'd4);
        send_job(32'd4);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       count = 5'd1;
                1:       count = 5'd0;
                2:       count = 5'd31;
                3:       count = 5'd4;
                4:       count = 5'd16;
                default: count = CFG_W'($urandom_range(0, 31));
            endcase
            set_workers(count);
            idle_level = (phase >= RANDOM_PHASES - 3) ? 0 : $urandom_range(0, 3);
            repeat (PHASE_JOBS) send_job(random_duration());
        end

        // Drain and decide.
        job_ch.valid <= 1'b0;
        idle_level = 0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #6000000;
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
